// ===== rtl/hgr_pkg.sv =====
// ---------------------------------------------------------------------------
// hgr_pkg: shared types and constants for the group restraint unit
// Request and response payload structs, request kinds, register indexes and
// the command and status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
package hgr_pkg;

   localparam logic [1:0] KIND_ACCEPT = 2'd0;
   localparam logic [1:0] KIND_REJECT = 2'd1;
   localparam logic [1:0] KIND_EVAL   = 2'd2;

   localparam logic [2:0] REG_HALF_K   = 3'd0;
   localparam logic [2:0] REG_FINAL    = 3'd1;
   localparam logic [2:0] REG_RAMP     = 3'd2;
   localparam logic [2:0] REG_START    = 3'd3;
   localparam logic [2:0] REG_MASK     = 3'd4;
   localparam logic [2:0] REG_SIZE_A   = 3'd5;
   localparam logic [2:0] REG_SIZE_B   = 3'd6;

   typedef struct packed {
      logic [1:0]         kind;
      logic               in_first;
      logic               in_second;
      logic signed [31:0] shift_x;
      logic signed [31:0] shift_y;
      logic signed [31:0] shift_z;
      logic [30:0]        step_number;
   } req_type;

   typedef struct packed {
      logic [31:0]        distance;
      logic [47:0]        energy;
      logic signed [47:0] force_res;
      logic [31:0]        ramp_length;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture request
      logic div_start; // start a divider pass
      logic div_ramp;  // pass is the ramp quotient, else a move quotient
      logic [1:0] axis;
      logic grp_b;     // move quotient targets the second group
      logic apply;     // add quotient to center
      logic sq_start;  // start square root
      logic fin;       // compute energy and force stage
      logic fin2;
      logic emit;      // load the response register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
      logic sq_done;
   } sts_type;

endpackage

// ===== rtl/harmonic_group_restraint_unit.sv =====
// Sequence: a move runs the serial 64-step divider once per axis for each
// group that the request selects, and a vertex may be in both groups; an
// evaluate runs the ramp divide (64 steps) and a 32-step square root first.
// Throughput: one request at a time; a new request is taken once the unit is
// idle, while a finished response may still wait in the output register.
// Reset: synchronous active high; centers zero, registers to defaults.
// ---------------------------------------------------------------------------
// harmonic_group_restraint_unit: top level of the group restraint unit
// Configuration registers, controller and datapath.
// ---------------------------------------------------------------------------
module harmonic_group_restraint_unit
   import hgr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic [31:0] half_k_ff, final_ff, start_ff;
   logic [30:0] ramp_ff;
   logic [2:0]  mask_ff;
   logic [15:0] size_a_ff, size_b_ff;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         half_k_ff <= '0; final_ff <= '0; ramp_ff <= '0; start_ff <= '0;
         mask_ff <= 3'd7; size_a_ff <= 16'd1; size_b_ff <= 16'd1;
      end else if (csr_we) begin
         case (csr_index)
            REG_HALF_K: half_k_ff <= csr_wdata;
            REG_FINAL:  final_ff  <= csr_wdata;
            REG_RAMP:   ramp_ff   <= csr_wdata[30:0];
            REG_START:  start_ff  <= csr_wdata;
            REG_MASK:   mask_ff   <= csr_wdata[2:0];
            REG_SIZE_A: size_a_ff <= csr_wdata[15:0];
            REG_SIZE_B: size_b_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   cmd_type cmd;
   sts_type sts;

   hgr_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready,
      .req_kind(req_data.kind), .req_first(req_data.in_first),
      .req_second(req_data.in_second),
      .rsp_valid, .rsp_ready, .cmd, .sts
   );

   hgr_datapath u_dp (
      .clock, .reset, .cmd, .sts, .req(req_data),
      .half_k(half_k_ff), .final_len(final_ff), .ramp_steps(ramp_ff),
      .start_len(start_ff), .axis_mask(mask_ff),
      .size_a(size_a_ff), .size_b(size_b_ff), .rsp(rsp_data)
   );

endmodule

// ===== rtl/hgr_datapath.sv =====
// ---------------------------------------------------------------------------
// hgr_datapath: centers, shared serial divider, square root and result math
// One restoring divider is used for both move quotients and the ramp
// quotient; the square root runs one result bit per cycle.
// ---------------------------------------------------------------------------
module hgr_datapath
   import hgr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  req_type     req,
   input  logic [31:0] half_k,
   input  logic [31:0] final_len,
   input  logic [30:0] ramp_steps,
   input  logic [31:0] start_len,
   input  logic [2:0]  axis_mask,
   input  logic [15:0] size_a,
   input  logic [15:0] size_b,
   output rsp_type     rsp
);

   req_type rq_ff;
   logic signed [31:0] ca_ff [3];
   logic signed [31:0] cb_ff [3];

   // divider: 64-bit magnitude dividend over 32-bit divisor
   logic [63:0] dq_ff;
   logic [32:0] drem_ff;
   logic [31:0] dden_ff;
   logic        dneg_ff;
   logic [6:0]  dcnt_ff;
   logic        dbusy_ff;

   // square root
   logic [63:0] sv_ff;
   logic [65:0] srem_ff;
   logic [32:0] sroot_ff;
   logic [5:0]  scnt_ff;
   logic        sbusy_ff;
   logic        sover_ff;

   logic [31:0] target_ff;
   logic [31:0] dist_ff;
   logic [32:0] mag_ff;
   logic        epos_ff;
   logic [63:0] e2_ff;
   logic [63:0] km_ff;
   rsp_type     rsp_ff, rsp_in;

   // divider operand selection
   logic signed [31:0] shv;
   logic [15:0]        sz;
   logic [63:0]        num_mag;
   logic               num_neg;
   logic signed [32:0] rdiff;
   logic signed [64:0] rprod;
   always_comb begin
      case (cmd.axis)
         2'd0:    shv = rq_ff.shift_x;
         2'd1:    shv = rq_ff.shift_y;
         default: shv = rq_ff.shift_z;
      endcase
      sz = cmd.grp_b ? size_b : size_a;
      if (sz == 16'd0) sz = 16'd1;
      rdiff = $signed({1'b0, final_len}) - $signed({1'b0, start_len});
      rprod = 65'(rdiff * $signed({1'b0, rq_ff.step_number}));
      if (cmd.div_ramp) begin
         num_neg = rprod[64];
         num_mag = rprod[64] ? 64'(-rprod) : rprod[63:0];
      end else begin
         num_neg = shv[31];
         num_mag = shv[31] ? {32'd0, -shv} : {32'd0, shv};
      end
   end

   logic [32:0] dtrial;
   assign dtrial = {drem_ff[31:0], dq_ff[63]} - {1'b0, dden_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
         dcnt_ff  <= '0;
      end else if (cmd.div_start) begin
         dbusy_ff <= 1'b1;
         dcnt_ff  <= 7'd64;
         dq_ff    <= num_mag;
         drem_ff  <= '0;
         dneg_ff  <= num_neg;
         dden_ff  <= cmd.div_ramp ? {1'b0, ramp_steps} : {16'd0, sz};
      end else if (dbusy_ff) begin
         if (!dtrial[32]) drem_ff <= dtrial;
         else drem_ff <= {drem_ff[31:0], dq_ff[63]};
         dq_ff   <= {dq_ff[62:0], !dtrial[32]};
         dcnt_ff <= dcnt_ff - 7'd1;
         if (dcnt_ff == 7'd1) dbusy_ff <= 1'b0;
      end
   end

   logic signed [64:0] quot;
   assign quot = dneg_ff ? -$signed({1'b0, dq_ff}) : $signed({1'b0, dq_ff});

   // center update with saturation
   logic signed [33:0] nc;
   logic signed [31:0] cur;
   always_comb begin
      cur = cmd.grp_b ? cb_ff[cmd.axis] : ca_ff[cmd.axis];
      if (rq_ff.kind == KIND_REJECT) nc = 34'(cur) - 34'(quot);
      else nc = 34'(cur) + 34'(quot);
   end
   logic signed [31:0] ncs;
   assign ncs = (nc > 34'sd2147483647) ? 32'sh7fffffff :
                (nc < -34'sd2147483648) ? 32'sh80000000 : nc[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            ca_ff[i] <= '0;
            cb_ff[i] <= '0;
         end
      end else if (cmd.apply) begin
         if (cmd.grp_b) cb_ff[cmd.axis] <= ncs;
         else ca_ff[cmd.axis] <= ncs;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) rq_ff <= req;
   end

   // sum of squares, registered at square root start
   logic [63:0] sq [3];
   logic [65:0] ssum;
   always_comb begin
      ssum = '0;
      for (int i = 0; i < 3; i++) begin
         logic signed [32:0] d;
         logic [32:0] a;
         d = 33'(ca_ff[i]) - 33'(cb_ff[i]);
         a = d[32] ? 33'(-d) : d;
         sq[i] = axis_mask[i] ? 64'(a * a) : 64'd0;
         ssum = ssum + 66'(sq[i]);
      end
   end

   logic [65:0] strial;
   assign strial = {srem_ff[63:0], sv_ff[63:62]} - {31'd0, sroot_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         sbusy_ff <= 1'b0;
         scnt_ff  <= '0;
      end else if (cmd.sq_start) begin
         sbusy_ff <= 1'b1;
         scnt_ff  <= 6'd32;
         sv_ff    <= ssum[63:0];
         sover_ff <= ssum[65:64] != 2'b00;
         srem_ff  <= '0;
         sroot_ff <= '0;
      end else if (sbusy_ff) begin
         if (!strial[65]) begin
            srem_ff  <= strial;
            sroot_ff <= {sroot_ff[31:0], 1'b1};
         end else begin
            srem_ff  <= {srem_ff[63:0], sv_ff[63:62]};
            sroot_ff <= {sroot_ff[31:0], 1'b0};
         end
         sv_ff   <= {sv_ff[61:0], 2'b00};
         scnt_ff <= scnt_ff - 6'd1;
         if (scnt_ff == 6'd1) sbusy_ff <= 1'b0;
      end
   end

   assign sts.div_done = !dbusy_ff && !cmd.div_start;
   assign sts.sq_done  = !sbusy_ff && !cmd.sq_start;

   // ramp target capture after divider
   logic ramp_on;
   assign ramp_on = ramp_steps != 31'd0 && rq_ff.step_number < ramp_steps;

   logic signed [33:0] etmp;
   logic [31:0]        dsel;
   assign dsel = sover_ff ? 32'hffffffff : sroot_ff[31:0];
   assign etmp = 34'(dsel) - 34'(target_ff);

   always_ff @(posedge clock) begin
      if (cmd.sq_start) begin
         target_ff <= ramp_on ? 32'(34'(start_len) + 34'(quot)) : final_len;
      end
      if (cmd.fin) begin
         dist_ff <= dsel;
         epos_ff <= !etmp[33] && etmp != 34'sd0;
         mag_ff  <= etmp[33] ? 33'(-etmp) : etmp[32:0];
      end
      if (cmd.fin2) begin
         e2_ff <= 64'(mag_ff * mag_ff);
         km_ff <= 64'(half_k * mag_ff);
      end
   end

   // energy: K*e2 >> 32, split into two 32x32 products
   logic [63:0] ph, pl;
   logic [64:0] en;
   logic [47:0] fm;
   logic        fsat_hi;
   always_comb begin
      ph = half_k * e2_ff[63:32];
      pl = half_k * e2_ff[31:0];
      en = {1'b0, ph} + 65'(pl[63:32]);
      fm = km_ff[63:16];
      fsat_hi = epos_ff ? (fm > 48'h800000000000) : (fm > 48'h7fffffffffff);
      rsp_in.distance    = dist_ff;
      rsp_in.energy      = (en > 65'hffffffffffff) ? 48'hffffffffffff : en[47:0];
      if (epos_ff) rsp_in.force_res = fsat_hi ? 48'sh800000000000 : 48'(-fm);
      else rsp_in.force_res = fsat_hi ? 48'sh7fffffffffff : fm;
      rsp_in.ramp_length = target_ff;
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.emit) rsp_ff <= rsp_in;
   end
   assign rsp = rsp_ff;

endmodule

// ===== rtl/hgr_ctrl.sv =====
// ---------------------------------------------------------------------------
// hgr_ctrl: sequencer for move and evaluate requests
// Walks group and axis quotients for moves, and ramp divide, square root
// and result stages for evaluates; holds the response register handshake.
// ---------------------------------------------------------------------------
module hgr_ctrl
   import hgr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_kind,
   input  logic       req_first,
   input  logic       req_second,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd,
   input  sts_type    sts
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MDIV = 3'd1;
   localparam logic [2:0] ST_MAPP = 3'd2;
   localparam logic [2:0] ST_RDIV = 3'd3;
   localparam logic [2:0] ST_SQRT = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;
   localparam logic [2:0] ST_FIN2 = 3'd6;
   localparam logic [2:0] ST_OUT  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic       grp_ff, grp_in;
   logic       ga_ff, ga_in, gb_ff, gb_in;
   logic       started_ff, started_in;
   logic       rv_ff, rv_in;

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rv_ff;

   always_comb begin
      state_in = state_ff; axis_in = axis_ff; grp_in = grp_ff;
      ga_in = ga_ff; gb_in = gb_ff; started_in = started_ff;
      rv_in = rv_ff && !rsp_ready;
      cmd = '0;
      cmd.axis = axis_ff;
      cmd.grp_b = grp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               axis_in = 2'd0;
               started_in = 1'b0;
               ga_in = req_first;
               gb_in = req_second;
               grp_in = !req_first;
               if (req_kind == KIND_EVAL) state_in = ST_RDIV;
               else if (req_kind == KIND_ACCEPT || req_kind == KIND_REJECT) begin
                  if (req_first || req_second) state_in = ST_MDIV;
               end
            end
         end
         ST_MDIV: begin
            if (!started_ff) begin
               cmd.div_start = 1'b1;
               started_in = 1'b1;
            end else if (sts.div_done) state_in = ST_MAPP;
         end
         ST_MAPP: begin
            cmd.apply = 1'b1;
            started_in = 1'b0;
            state_in = ST_MDIV;
            if (axis_ff == 2'd2) begin
               axis_in = 2'd0;
               if (!grp_ff && gb_ff) grp_in = 1'b1;
               else state_in = ST_IDLE;
            end else axis_in = axis_ff + 2'd1;
         end
         ST_RDIV: begin
            cmd.div_ramp = 1'b1;
            if (!started_ff) begin
               cmd.div_start = 1'b1;
               started_in = 1'b1;
            end else if (sts.div_done) begin
               cmd.sq_start = 1'b1;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: if (sts.sq_done) state_in = ST_FIN;
         ST_FIN: begin
            cmd.fin = 1'b1;
            state_in = ST_FIN2;
         end
         ST_FIN2: begin
            cmd.fin2 = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rv_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               rv_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff <= '0; grp_ff <= 1'b0; ga_ff <= 1'b0; gb_ff <= 1'b0;
         started_ff <= 1'b0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; axis_ff <= axis_in; grp_ff <= grp_in;
         ga_ff <= ga_in; gb_ff <= gb_in; started_ff <= started_in;
         rv_ff <= rv_in;
      end
   end

   // checks
   a_apply_in_move: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |-> (ga_ff || gb_ff)) else $error("apply without group");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rsp_ready |=> rv_ff) else $error("response dropped");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_ready) else $error("accept while busy");
endmodule
